### hw/rtl/lcb_pkg.sv
package lcb_pkg;

  localparam int unsigned COLOR_W = 15;
  localparam int unsigned CH_W    = 5;
  localparam int unsigned NUM_BG  = 4;
  localparam int unsigned NUM_LYR = NUM_BG + 1;
  localparam int unsigned MASK_W  = 6;
  localparam int unsigned CFG_W   = 15;

  localparam logic [CH_W-1:0] CH_MAX   = 5'd31;
  localparam logic [CH_W-1:0] COEF_MAX = 5'd16;

  typedef logic [COLOR_W-1:0] color_t;

  // layer codes double as bit positions in the six-bit masks
  typedef enum logic [2:0] {
    LAYER_BG0    = 3'd0,
    LAYER_BG1    = 3'd1,
    LAYER_BG2    = 3'd2,
    LAYER_BG3    = 3'd3,
    LAYER_SPRITE = 3'd4,
    LAYER_BACK   = 3'd5
  } layer_t;

  typedef enum logic [1:0] {
    EFF_NONE     = 2'd0,
    EFF_BLEND    = 2'd1,
    EFF_BRIGHTEN = 2'd2,
    EFF_DARKEN   = 2'd3
  } effect_t;

  typedef enum logic [2:0] {
    REG_DISPLAY_CONTROL = 3'd0,
    REG_BG_PRIORITIES   = 3'd1,
    REG_WINDOW_INSIDE   = 3'd2,
    REG_WINDOW_OUTSIDE  = 3'd3,
    REG_BLEND_CONTROL   = 3'd4,
    REG_BLEND_COEFS     = 3'd5,
    REG_BRIGHTNESS      = 3'd6,
    REG_BACKDROP        = 3'd7
  } cfg_idx_t;

  // outcome of window and priority selection, handed to the effect stage
  typedef struct packed {
    layer_t top_layer;
    layer_t below_layer;
    color_t top_color;
    color_t below_color;
    logic   top_semi;
    logic   effect_en;
  } sel_t;

  function automatic logic [CH_W-1:0] clamp16(input logic [CH_W-1:0] v);
    return (v > COEF_MAX) ? COEF_MAX : v;
  endfunction

endpackage

### hw/rtl/lcb_select.sv
module lcb_select (
  input  logic [7:0]                               display_control,
  input  logic [7:0]                               bg_priorities,
  input  logic [11:0]                              window_inside,
  input  logic [11:0]                              window_outside,
  input  lcb_pkg::color_t                          back_color,
  input  lcb_pkg::color_t [lcb_pkg::NUM_BG-1:0]    bg_colors,
  input  logic [lcb_pkg::NUM_BG-1:0]               bg_opaque,
  input  lcb_pkg::color_t                          sprite_color,
  input  logic                                     sprite_opaque,
  input  logic [1:0]                               sprite_priority,
  input  logic                                     sprite_semi_transparent,
  input  logic                                     sprite_window,
  input  logic                                     inside_window0,
  input  logic                                     inside_window1,
  output lcb_pkg::sel_t                            sel
);

  logic [lcb_pkg::MASK_W-1:0]  vis;
  logic [lcb_pkg::NUM_LYR-1:0] elig;
  logic [4:0]                  key [lcb_pkg::NUM_LYR];
  logic [2:0]                  rank [lcb_pkg::NUM_LYR];
  lcb_pkg::color_t             col [lcb_pkg::NUM_LYR];

  // window region, highest priority region first
  always_comb begin
    if (display_control[7:5] == 3'b000) begin
      vis = '1;
    end else if (display_control[5] && inside_window0) begin
      vis = window_inside[5:0];
    end else if (display_control[6] && inside_window1) begin
      vis = window_inside[11:6];
    end else if (display_control[7] && sprite_window) begin
      vis = window_outside[11:6];
    end else begin
      vis = window_outside[5:0];
    end
  end

  // key: priority, then tie order (sprite first, then lower background)
  always_comb begin
    for (int k = 0; k < lcb_pkg::NUM_BG; k++) begin
      elig[k] = display_control[k] && vis[k] && bg_opaque[k];
      key[k]  = {bg_priorities[2*k +: 2], 3'(k + 1)};
      col[k]  = bg_colors[k];
    end
    elig[lcb_pkg::LAYER_SPRITE] = display_control[lcb_pkg::LAYER_SPRITE] &&
                                  vis[lcb_pkg::LAYER_SPRITE] && sprite_opaque;
    key[lcb_pkg::LAYER_SPRITE]  = {sprite_priority, 3'd0};
    col[lcb_pkg::LAYER_SPRITE]  = sprite_color;
  end

  // rank = number of eligible layers that beat this one
  always_comb begin
    for (int i = 0; i < lcb_pkg::NUM_LYR; i++) begin
      rank[i] = '0;
      for (int j = 0; j < lcb_pkg::NUM_LYR; j++) begin
        if (j != i && elig[j] && key[j] < key[i]) begin
          rank[i] = rank[i] + 3'd1;
        end
      end
    end
  end

  always_comb begin
    sel.top_layer   = lcb_pkg::LAYER_BACK;
    sel.below_layer = lcb_pkg::LAYER_BACK;
    sel.top_color   = back_color;
    sel.below_color = back_color;
    for (int i = 0; i < lcb_pkg::NUM_LYR; i++) begin
      if (elig[i] && rank[i] == 3'd0) begin
        sel.top_layer = lcb_pkg::layer_t'(3'(i));
        sel.top_color = col[i];
      end
      if (elig[i] && rank[i] == 3'd1) begin
        sel.below_layer = lcb_pkg::layer_t'(3'(i));
        sel.below_color = col[i];
      end
    end
    sel.top_semi  = (sel.top_layer == lcb_pkg::LAYER_SPRITE) && sprite_semi_transparent;
    sel.effect_en = vis[5];
  end

endmodule

### hw/rtl/lcb_effect.sv
module lcb_effect (
  input  lcb_pkg::sel_t   sel,
  input  logic [13:0]     blend_control,
  input  logic [9:0]      blend_coefficients,
  input  logic [4:0]      brightness_coefficient,
  output lcb_pkg::color_t color
);

  logic [4:0]        eva, evb, evy;
  logic              above, below, apply;
  lcb_pkg::effect_t  effect;
  logic [4:0]        c1 [3];
  logic [4:0]        c2 [3];
  logic [9:0]        blend_sum [3];
  logic [8:0]        bright_sum [3];
  logic [8:0]        dark_sum [3];
  logic [5:0]        blend_q [3];
  lcb_pkg::color_t   fx_color;

  assign eva = lcb_pkg::clamp16(blend_coefficients[4:0]);
  assign evb = lcb_pkg::clamp16(blend_coefficients[9:5]);
  assign evy = lcb_pkg::clamp16(brightness_coefficient);

  // semi-transparent sprite forces alpha blend over a second target
  always_comb begin
    above  = blend_control[sel.top_layer] || sel.top_semi;
    below  = blend_control[4'd8 + 4'(sel.below_layer)];
    effect = lcb_pkg::effect_t'(blend_control[7:6]);
    if (sel.top_semi && below) begin
      effect = lcb_pkg::EFF_BLEND;
    end
    apply = sel.effect_en && (effect != lcb_pkg::EFF_NONE) && above &&
            (below || effect != lcb_pkg::EFF_BLEND);
  end

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      c1[s]         = sel.top_color[5*s +: 5];
      c2[s]         = sel.below_color[5*s +: 5];
      blend_sum[s]  = 10'(eva) * 10'(c1[s]) + 10'(evb) * 10'(c2[s]);
      blend_q[s]    = blend_sum[s][9:4];
      bright_sum[s] = {c1[s], 4'b0000} + 9'(lcb_pkg::CH_MAX - c1[s]) * 9'(evy);
      dark_sum[s]   = {c1[s], 4'b0000} - 9'(c1[s]) * 9'(evy);
      case (effect)
        lcb_pkg::EFF_BLEND: begin
          fx_color[5*s +: 5] = (blend_q[s] > 6'(lcb_pkg::CH_MAX)) ? lcb_pkg::CH_MAX
                                                                 : blend_q[s][4:0];
        end
        lcb_pkg::EFF_BRIGHTEN: begin
          fx_color[5*s +: 5] = bright_sum[s][8:4];
        end
        lcb_pkg::EFF_DARKEN: begin
          fx_color[5*s +: 5] = dark_sum[s][8:4];
        end
        default: begin
          fx_color[5*s +: 5] = c1[s];
        end
      endcase
    end
  end

  assign color = apply ? fx_color : sel.top_color;

endmodule

### hw/rtl/layer_compositor_with_blending.sv
// Layer compositor: one transaction carries the four background colours, the
// sprite colour and flags, and the window flags of one screen position, and
// yields one 15-bit colour (red in bits 4:0, green 9:5, blue 14:10). Window 0
// beats window 1, which beats the object window, which beats the outside
// region; with no window enabled every layer and the effect are visible. The
// top two opaque layers are picked by priority (sprite wins ties, then the
// lower background), with the backdrop filling any empty place, and alpha
// blend, brighten or darken is applied with coefficients clamped at 16.
// Throughput is one transaction per clock while the output is not stalled.
// The input register holds the accepted transaction, and the selection and
// effect logic feed the result register from it, so a transaction passes the
// input register and then the result register; a stalled output holds the
// result register, and once the input register is full it holds that too
// and drops input ready. Configuration writes take effect on the next clock
// and should only be made while idle.
module layer_compositor_with_blending (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_write_en,
  input  logic [2:0]                cfg_index,
  input  logic [lcb_pkg::CFG_W-1:0] cfg_data,
  // pixel input
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [14:0]               bg0_color,
  input  logic [14:0]               bg1_color,
  input  logic [14:0]               bg2_color,
  input  logic [14:0]               bg3_color,
  input  logic [3:0]                bg_opaque,
  input  logic [14:0]               sprite_color,
  input  logic                      sprite_opaque,
  input  logic [1:0]                sprite_priority,
  input  logic                      sprite_semi_transparent,
  input  logic                      sprite_window,
  input  logic                      inside_window0,
  input  logic                      inside_window1,
  // composed pixel output
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [14:0]               pixel_color
);

  // configuration registers
  logic [7:0]      display_control;
  logic [7:0]      bg_priorities;
  logic [11:0]     window_inside;
  logic [11:0]     window_outside;
  logic [13:0]     blend_control;
  logic [9:0]      blend_coefficients;
  logic [4:0]      brightness_coefficient;
  lcb_pkg::color_t back_color;

  // input register stage
  logic                                  in_full;
  lcb_pkg::color_t [lcb_pkg::NUM_BG-1:0] bg_colors_q;
  logic [3:0]                            bg_opaque_q;
  lcb_pkg::color_t                       sprite_color_q;
  logic                                  sprite_opaque_q;
  logic [1:0]                            sprite_priority_q;
  logic                                  sprite_semi_q;
  logic                                  sprite_window_q;
  logic                                  inside_window0_q;
  logic                                  inside_window1_q;

  logic            in_fire;
  logic            advance;
  lcb_pkg::sel_t   sel;
  lcb_pkg::color_t composed;

  // the result register frees when empty or being taken; the input register
  // frees when empty or moving on, so a new transaction enters while an
  // earlier result still waits
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_control        <= '0;
      bg_priorities          <= '0;
      window_inside          <= '0;
      window_outside         <= '0;
      blend_control          <= '0;
      blend_coefficients     <= '0;
      brightness_coefficient <= '0;
      back_color             <= '0;
    end else if (cfg_write_en) begin
      case (lcb_pkg::cfg_idx_t'(cfg_index))
        lcb_pkg::REG_DISPLAY_CONTROL: display_control        <= cfg_data[7:0];
        lcb_pkg::REG_BG_PRIORITIES:   bg_priorities          <= cfg_data[7:0];
        lcb_pkg::REG_WINDOW_INSIDE:   window_inside          <= cfg_data[11:0];
        lcb_pkg::REG_WINDOW_OUTSIDE:  window_outside         <= cfg_data[11:0];
        lcb_pkg::REG_BLEND_CONTROL:   blend_control          <= cfg_data[13:0];
        lcb_pkg::REG_BLEND_COEFS:     blend_coefficients     <= cfg_data[9:0];
        lcb_pkg::REG_BRIGHTNESS:      brightness_coefficient <= cfg_data[4:0];
        lcb_pkg::REG_BACKDROP:        back_color             <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  // input register: payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bg_colors_q       <= {bg3_color, bg2_color, bg1_color, bg0_color};
      bg_opaque_q       <= bg_opaque;
      sprite_color_q    <= sprite_color;
      sprite_opaque_q   <= sprite_opaque;
      sprite_priority_q <= sprite_priority;
      sprite_semi_q     <= sprite_semi_transparent;
      sprite_window_q   <= sprite_window;
      inside_window0_q  <= inside_window0;
      inside_window1_q  <= inside_window1;
    end
  end

  // window region and top-two layer pick
  lcb_select u_select (
    .display_control         (display_control),
    .bg_priorities           (bg_priorities),
    .window_inside           (window_inside),
    .window_outside          (window_outside),
    .back_color              (back_color),
    .bg_colors               (bg_colors_q),
    .bg_opaque               (bg_opaque_q),
    .sprite_color            (sprite_color_q),
    .sprite_opaque           (sprite_opaque_q),
    .sprite_priority         (sprite_priority_q),
    .sprite_semi_transparent (sprite_semi_q),
    .sprite_window           (sprite_window_q),
    .inside_window0          (inside_window0_q),
    .inside_window1          (inside_window1_q),
    .sel                     (sel)
  );

  // colour special effects on the chosen pair
  lcb_effect u_effect (
    .sel                    (sel),
    .blend_control          (blend_control),
    .blend_coefficients     (blend_coefficients),
    .brightness_coefficient (brightness_coefficient),
    .color                  (composed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_color <= composed;
    end
  end

  // an empty input register always takes a transaction
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> in_ready)
    else $error("input register empty but not ready");

  // an accepted transaction lands in the input register
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_full)
    else $error("accepted transaction lost");

  // a held transaction moves to the result register once it is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("transaction did not reach result register");

  // both stages full and output stalled: no further acceptance
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && !out_ready) |-> !in_ready)
    else $error("accepted while both stages full");

  // a stalled output keeps the input register filled
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && !out_ready) |=> in_full)
    else $error("input register dropped while stalled");

endmodule

### verif/tb_layer_compositor_with_blending.sv
module tb_layer_compositor_with_blending;

  // watchdog: cycles in a row with no transaction on either side
  localparam int unsigned QUIET_LIMIT  = 4000;
  // long output hold-off so that the pipe fills and pushes back
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_PERCENT = 19;
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PHASE_PIXELS = 50;
  // weights are in sixteenths, so sixteen stands for one
  localparam int unsigned UNITY        = 16;

  // one screen position as the block sees it
  typedef struct packed {
    lcb_pkg::color_t bg0;
    lcb_pkg::color_t bg1;
    lcb_pkg::color_t bg2;
    lcb_pkg::color_t bg3;
    logic [3:0]      bg_opq;
    lcb_pkg::color_t spr;
    logic            spr_opq;
    logic [1:0]      spr_pri;
    logic            semi;
    logic            spr_win;
    logic            in_w0;
    logic            in_w1;
  } pixel_in_t;

  // composed colours still owed by the block, oldest first
  class pixel_tally;
    lcb_pkg::color_t pending[$];
    int unsigned     seen;
    int unsigned     bad;

    function void note_accepted(lcb_pkg::color_t want);
      pending.push_back(want);
    endfunction

    function void check_pixel(lcb_pkg::color_t got);
      lcb_pkg::color_t want;
      seen++;
      if (pending.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("%0t: unexpected output transaction, pixel_color=%h", $realtime, got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        bad++;
        if (bad <= 10)
          $display("%0t: pixel_color mismatch, expected %h actual %h", $realtime, want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write_en;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [14:0] bg0_color;
  logic [14:0] bg1_color;
  logic [14:0] bg2_color;
  logic [14:0] bg3_color;
  logic [3:0]  bg_opaque;
  logic [14:0] sprite_color;
  logic        sprite_opaque;
  logic [1:0]  sprite_priority;
  logic        sprite_semi_transparent;
  logic        sprite_window;
  logic        inside_window0;
  logic        inside_window1;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] pixel_color;

  // our own copy of the register file, zero after reset
  logic [7:0]      disp_ctl   = '0;
  logic [7:0]      bg_prio    = '0;
  logic [11:0]     win_in     = '0;
  logic [11:0]     win_out    = '0;
  logic [13:0]     blend_ctl  = '0;
  logic [9:0]      blend_coef = '0;
  logic [4:0]      bright     = '0;
  lcb_pkg::color_t backdrop   = '0;

  pixel_tally  tally;
  bit          steady       = 1'b0;  // no idling on either side while set
  bit          hold_request = 1'b0;  // asks the receiver for one long hold-off
  int unsigned pixels_sent  = 0;
  int unsigned settings     = 0;
  int unsigned quiet_cycles = 0;

  layer_compositor_with_blending i_dut (
    .clk                     (clk),
    .rst                     (rst),
    .cfg_write_en            (cfg_write_en),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .bg0_color               (bg0_color),
    .bg1_color               (bg1_color),
    .bg2_color               (bg2_color),
    .bg3_color               (bg3_color),
    .bg_opaque               (bg_opaque),
    .sprite_color            (sprite_color),
    .sprite_opaque           (sprite_opaque),
    .sprite_priority         (sprite_priority),
    .sprite_semi_transparent (sprite_semi_transparent),
    .sprite_window           (sprite_window),
    .inside_window0          (inside_window0),
    .inside_window1          (inside_window1),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .pixel_color             (pixel_color)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // colour arithmetic, channel by channel: weights clamp at sixteen, the sum is
  // truncated to whole steps and each channel saturates at full scale
  // ---------------------------------------------------------------------------
  function automatic lcb_pkg::color_t apply_effect(lcb_pkg::color_t hi, lcb_pkg::color_t lo,
                                                   lcb_pkg::effect_t eff);
    int unsigned     eva;
    int unsigned     evb;
    int unsigned     evy;
    int unsigned     c1;
    int unsigned     c2;
    int unsigned     ch;
    lcb_pkg::color_t res;
    eva = (blend_coef[4:0] > lcb_pkg::COEF_MAX) ? lcb_pkg::COEF_MAX : blend_coef[4:0];
    evb = (blend_coef[9:5] > lcb_pkg::COEF_MAX) ? lcb_pkg::COEF_MAX : blend_coef[9:5];
    evy = (bright > lcb_pkg::COEF_MAX) ? lcb_pkg::COEF_MAX : bright;
    res = '0;
    for (int s = 0; s < 3; s++) begin
      c1 = hi[lcb_pkg::CH_W*s +: lcb_pkg::CH_W];
      c2 = lo[lcb_pkg::CH_W*s +: lcb_pkg::CH_W];
      case (eff)
        lcb_pkg::EFF_BLEND:    ch = (eva * c1 + evb * c2) >> 4;
        lcb_pkg::EFF_BRIGHTEN: ch = (UNITY * c1 + (lcb_pkg::CH_MAX - c1) * evy) >> 4;
        lcb_pkg::EFF_DARKEN:   ch = (UNITY * c1 - c1 * evy) >> 4;
        default:               ch = c1;
      endcase
      if (ch > lcb_pkg::CH_MAX)
        ch = lcb_pkg::CH_MAX;
      res[lcb_pkg::CH_W*s +: lcb_pkg::CH_W] = ch[lcb_pkg::CH_W-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // expected colour for one position under the current register settings
  // ---------------------------------------------------------------------------
  function automatic lcb_pkg::color_t compose_pixel(pixel_in_t px);
    logic [5:0]       vis;
    lcb_pkg::layer_t  top_l;
    lcb_pkg::layer_t  low_l;
    lcb_pkg::color_t  top_c;
    lcb_pkg::color_t  low_c;
    lcb_pkg::color_t  bgc [4];
    lcb_pkg::effect_t eff;
    logic             semi_top;
    logic             above;
    logic             below;
    bgc[0] = px.bg0;
    bgc[1] = px.bg1;
    bgc[2] = px.bg2;
    bgc[3] = px.bg3;
    top_l  = lcb_pkg::LAYER_BACK;
    low_l  = lcb_pkg::LAYER_BACK;
    top_c  = backdrop;
    low_c  = backdrop;

    // region: window 0, then window 1, then object window, else outside
    if (disp_ctl[5] && px.in_w0)
      vis = win_in[5:0];
    else if (disp_ctl[6] && px.in_w1)
      vis = win_in[11:6];
    else if (disp_ctl[7] && px.spr_win)
      vis = win_out[11:6];
    else
      vis = win_out[5:0];
    if (disp_ctl[7:5] == 3'b000)
      vis = '1;

    // lowest priority first, every enabled, visible, opaque layer goes on top of the stack
    for (int pr = 3; pr >= 0; pr--) begin
      for (int k = 3; k >= 0; k--) begin
        if (disp_ctl[k] && bg_prio[2*k +: 2] == pr && vis[k] && px.bg_opq[k]) begin
          low_l = top_l;
          low_c = top_c;
          top_l = lcb_pkg::layer_t'(k);
          top_c = bgc[k];
        end
      end
      if (disp_ctl[lcb_pkg::LAYER_SPRITE] && px.spr_pri == pr &&
          vis[lcb_pkg::LAYER_SPRITE] && px.spr_opq) begin
        low_l = top_l;
        low_c = top_c;
        top_l = lcb_pkg::LAYER_SPRITE;
        top_c = px.spr;
      end
    end

    if (vis[5]) begin
      eff      = lcb_pkg::effect_t'(blend_ctl[7:6]);
      semi_top = (top_l == lcb_pkg::LAYER_SPRITE) && px.semi;
      above    = blend_ctl[top_l] || semi_top;
      below    = blend_ctl[8 + low_l];
      // a semi-transparent sprite over a second target always blends
      if (semi_top && below)
        eff = lcb_pkg::EFF_BLEND;
      if (eff != lcb_pkg::EFF_NONE && above && (below || eff != lcb_pkg::EFF_BLEND))
        top_c = apply_effect(top_c, low_c, eff);
    end
    return top_c;
  endfunction

  function automatic logic [13:0] blend_word(logic [5:0] first, lcb_pkg::effect_t eff,
                                             logic [5:0] second);
    return {second, eff, first};
  endfunction

  // mostly random colours, with black and white now and then
  function automatic lcb_pkg::color_t rand_color();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return lcb_pkg::color_t'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t px;
    px.bg0     = rand_color();
    px.bg1     = rand_color();
    px.bg2     = rand_color();
    px.bg3     = rand_color();
    px.bg_opq  = 4'($urandom);
    px.spr     = rand_color();
    px.spr_opq = ($urandom_range(3) != 0);
    px.spr_pri = 2'($urandom);
    px.semi    = 1'($urandom);
    px.spr_win = 1'($urandom);
    px.in_w0   = 1'($urandom);
    px.in_w1   = 1'($urandom);
    return px;
  endfunction

  // fixed palette for the directed part; win is {object window, win1, win0}
  function automatic pixel_in_t stack_pixel(logic [3:0] bg_opq, logic spr_opq,
                                            logic [1:0] spr_pri, logic semi,
                                            logic [2:0] win);
    pixel_in_t px;
    px.bg0     = 15'h1234;
    px.bg1     = 15'h2345;
    px.bg2     = 15'h3456;
    px.bg3     = 15'h4567;
    px.bg_opq  = bg_opq;
    px.spr     = 15'h5AB5;
    px.spr_opq = spr_opq;
    px.spr_pri = spr_pri;
    px.semi    = semi;
    px.spr_win = win[2];
    px.in_w1   = win[1];
    px.in_w0   = win[0];
    return px;
  endfunction

  // offer one pixel, with random idle cycles first, and wait for the transaction
  task automatic send_pixel(input pixel_in_t px);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    bg0_color               <= px.bg0;
    bg1_color               <= px.bg1;
    bg2_color               <= px.bg2;
    bg3_color               <= px.bg3;
    bg_opaque               <= px.bg_opq;
    sprite_color            <= px.spr;
    sprite_opaque           <= px.spr_opq;
    sprite_priority         <= px.spr_pri;
    sprite_semi_transparent <= px.semi;
    sprite_window           <= px.spr_win;
    inside_window0          <= px.in_w0;
    inside_window1          <= px.in_w1;
    in_valid                <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tally.note_accepted(compose_pixel(px));
    pixels_sent++;
  endtask

  task automatic write_reg(input lcb_pkg::cfg_idx_t idx, input logic [14:0] val);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    @(posedge clk);
    case (idx)
      lcb_pkg::REG_DISPLAY_CONTROL: disp_ctl   = val[7:0];
      lcb_pkg::REG_BG_PRIORITIES:   bg_prio    = val[7:0];
      lcb_pkg::REG_WINDOW_INSIDE:   win_in     = val[11:0];
      lcb_pkg::REG_WINDOW_OUTSIDE:  win_out    = val[11:0];
      lcb_pkg::REG_BLEND_CONTROL:   blend_ctl  = val[13:0];
      lcb_pkg::REG_BLEND_COEFS:     blend_coef = val[9:0];
      lcb_pkg::REG_BRIGHTNESS:      bright     = val[4:0];
      lcb_pkg::REG_BACKDROP:        backdrop   = val;
      default: ;
    endcase
  endtask

  // let the pipe drain, then rewrite the whole register file
  task automatic load_config(input logic [7:0] d, input logic [7:0] p,
                             input logic [11:0] wi, input logic [11:0] wo,
                             input logic [13:0] bc, input logic [9:0] co,
                             input logic [4:0] br, input lcb_pkg::color_t bd);
    @(negedge clk);
    in_valid <= 1'b0;
    while (tally.pending.size() != 0)
      @(posedge clk);
    // two-stage pipe, so the spare wait below is plenty
    repeat (4) @(posedge clk);
    write_reg(lcb_pkg::REG_DISPLAY_CONTROL, 15'(d));
    write_reg(lcb_pkg::REG_BG_PRIORITIES,   15'(p));
    write_reg(lcb_pkg::REG_WINDOW_INSIDE,   15'(wi));
    write_reg(lcb_pkg::REG_WINDOW_OUTSIDE,  15'(wo));
    write_reg(lcb_pkg::REG_BLEND_CONTROL,   15'(bc));
    write_reg(lcb_pkg::REG_BLEND_COEFS,     15'(co));
    write_reg(lcb_pkg::REG_BRIGHTNESS,      15'(br));
    write_reg(lcb_pkg::REG_BACKDROP,        bd);
    @(negedge clk);
    cfg_write_en <= 1'b0;
    settings++;
  endtask

  task automatic random_config();
    logic [7:0] d;
    d = 8'($urandom);
    // layers mostly on, windows off in about half the settings
    if ($urandom_range(1))
      d[4:0] = '1;
    if ($urandom_range(1))
      d[7:5] = '0;
    load_config(d, 8'($urandom), 12'($urandom), 12'($urandom), 14'($urandom),
                10'($urandom), 5'($urandom), rand_color());
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // output transactions are checked at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tally.check_pixel(pixel_color);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tally                   = new();
    rst                     = 1'b1;
    cfg_write_en            = 1'b0;
    cfg_index               = lcb_pkg::REG_DISPLAY_CONTROL;
    cfg_data                = '0;
    in_valid                = 1'b0;
    bg0_color               = '0;
    bg1_color               = '0;
    bg2_color               = '0;
    bg3_color               = '0;
    bg_opaque               = '0;
    sprite_color            = '0;
    sprite_opaque           = 1'b0;
    sprite_priority         = '0;
    sprite_semi_transparent = 1'b0;
    sprite_window           = 1'b0;
    inside_window0          = 1'b0;
    inside_window1          = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at their reset value: nothing enabled, backdrop black
    send_pixel(pixel_in_t'('1));
    send_pixel(pixel_in_t'('0));

    // all layers at equal priority, blend with both weights over sixteen
    load_config(8'h1F, 8'h00, 12'h000, 12'h000,
                blend_word(6'h3F, lcb_pkg::EFF_BLEND, 6'h3F), 10'h3FF, 5'd0, 15'h7FFF);
    send_pixel(stack_pixel(4'hF, 1'b1, 2'd0, 1'b0, 3'b000)); // sprite wins the tie
    send_pixel(stack_pixel(4'hF, 1'b0, 2'd0, 1'b0, 3'b000)); // lower background wins
    send_pixel(stack_pixel(4'h8, 1'b0, 2'd0, 1'b0, 3'b000)); // single layer over backdrop
    send_pixel(stack_pixel(4'h0, 1'b0, 2'd0, 1'b0, 3'b000)); // backdrop with itself

    // effect field off, BG3 the only second target, backgrounds at spread priorities
    load_config(8'h1F, 8'h1B, 12'h000, 12'h000,
                blend_word(6'h01, lcb_pkg::EFF_NONE, 6'h08), 10'h108, 5'd31, 15'h0421);
    send_pixel(stack_pixel(4'h8, 1'b1, 2'd0, 1'b1, 3'b000)); // semi sprite forces blend
    send_pixel(stack_pixel(4'h1, 1'b1, 2'd1, 1'b1, 3'b000)); // below is not a target
    send_pixel(stack_pixel(4'hF, 1'b1, 2'd3, 1'b1, 3'b000)); // semi sprite underneath
    send_pixel(stack_pixel(4'h8, 1'b1, 2'd0, 1'b0, 3'b000)); // plain sprite, no effect

    // brighten with a factor above sixteen
    load_config(8'h1F, 8'h00, 12'h000, 12'h000,
                blend_word(6'h3F, lcb_pkg::EFF_BRIGHTEN, 6'h00), 10'h000, 5'd31, 15'h001F);
    send_pixel(stack_pixel(4'hF, 1'b0, 2'd0, 1'b0, 3'b000));
    send_pixel(stack_pixel(4'h0, 1'b0, 2'd0, 1'b0, 3'b000));

    // darken
    load_config(8'h1F, 8'h00, 12'h000, 12'h000,
                blend_word(6'h3F, lcb_pkg::EFF_DARKEN, 6'h00), 10'h000, 5'd7, 15'h7FFF);
    send_pixel(stack_pixel(4'hF, 1'b0, 2'd0, 1'b0, 3'b000));
    send_pixel(stack_pixel(4'h0, 1'b1, 2'd2, 1'b0, 3'b000));

    // all three windows on, each region showing a different layer set
    load_config(8'hFF, 8'h00, 12'h0A1, 12'hA10,
                blend_word(6'h3F, lcb_pkg::EFF_BLEND, 6'h3F), 10'h108, 5'd0, 15'h3C0F);
    send_pixel(stack_pixel(4'hF, 1'b1, 2'd0, 1'b0, 3'b111)); // window 0 wins
    send_pixel(stack_pixel(4'hF, 1'b1, 2'd0, 1'b0, 3'b110)); // window 1 next
    send_pixel(stack_pixel(4'hF, 1'b1, 2'd0, 1'b0, 3'b100)); // object window
    send_pixel(stack_pixel(4'hF, 1'b1, 2'd0, 1'b0, 3'b000)); // outside

    // random part: first all-zero and all-ones settings, then random ones
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0)
        load_config('0, '0, '0, '0, '0, '0, '0, '0);
      else if (ph == 1)
        load_config('1, '1, '1, '1, '1, '1, '1, '1);
      else
        random_config();
      steady = (ph == 4);
      // sender keeps offering while the output is held off
      if (ph == 6)
        hold_request = 1'b1;
      for (int n = 0; n < PHASE_PIXELS; n++)
        send_pixel(rand_pixel());
      steady = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tally.pending.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d pixels composed and checked under %0d register settings,",
             tally.seen, settings);
    $display("windows, priorities, blend, brighten and darken, with a long output hold-off");
    if (tally.bad == 0 && pixels_sent == tally.seen)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### layer_compositor_with_blending.f
hw/rtl/lcb_pkg.sv
hw/rtl/lcb_select.sv
hw/rtl/lcb_effect.sv
hw/rtl/layer_compositor_with_blending.sv
verif/tb_layer_compositor_with_blending.sv
